### rtl/core/cfp_pkg.sv
package cfp_pkg;

  // Frame bytes
  localparam logic [7:0] CH_START  = 8'h4D;  // 'M'
  localparam logic [7:0] CH_I      = 8'h49;
  localparam logic [7:0] CH_C      = 8'h43;
  localparam logic [7:0] CH_T      = 8'h54;
  localparam logic [7:0] CH_R      = 8'h52;
  localparam logic [7:0] CH_V      = 8'h56;
  localparam logic [7:0] CH_H      = 8'h48;
  localparam logic [7:0] CH_N      = 8'h4E;
  localparam logic [7:0] CH_P      = 8'h50;
  localparam logic [7:0] CH_S      = 8'h53;
  localparam logic [7:0] CH_F      = 8'h46;
  localparam logic [7:0] CH_OPT_O  = 8'h4F;
  localparam logic [7:0] CH_OPT_X  = 8'h58;

  localparam logic [7:0] HOUR_LIMIT   = 8'd24;
  localparam logic [7:0] MINUTE_LIMIT = 8'd60;

  localparam int unsigned IN_DATA_W  = 8;
  localparam int unsigned OUT_DATA_W = 24;
  localparam int unsigned OUT_USER_W = 5;

  typedef enum logic [3:0] {
    KIND_INVALID = 4'd0,
    KIND_I       = 4'd1,
    KIND_C       = 4'd2,
    KIND_T       = 4'd3,
    KIND_R       = 4'd4,
    KIND_V       = 4'd5,
    KIND_H       = 4'd6,
    KIND_N       = 4'd7,
    KIND_P       = 4'd8,
    KIND_S       = 4'd9,
    KIND_F       = 4'd10
  } kind_t;

  typedef enum logic [2:0] {
    PH_HUNT,
    PH_TYPE,
    PH_VOTE,
    PH_HOUR,
    PH_MINUTE,
    PH_LENGTH,
    PH_PAYLOAD
  } phase_t;

  typedef struct packed {
    kind_t      frame_kind;
    logic [7:0] arg_first;
    logic [5:0] arg_second;
    logic [7:0] payload_index;
    logic       has_payload;
    logic       frame_last;
  } cfp_result_t;

  // Map a type byte onto its frame kind
  function automatic kind_t type_code(input logic [7:0] b);
    kind_t k;
    unique case (b)
      CH_I:    k = KIND_I;
      CH_C:    k = KIND_C;
      CH_T:    k = KIND_T;
      CH_R:    k = KIND_R;
      CH_V:    k = KIND_V;
      CH_H:    k = KIND_H;
      CH_N:    k = KIND_N;
      CH_P:    k = KIND_P;
      CH_S:    k = KIND_S;
      CH_F:    k = KIND_F;
      default: k = KIND_INVALID;
    endcase
    return k;
  endfunction

endpackage

### rtl/core/cfp_in_stage.sv
module cfp_in_stage (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,
  input  logic       advance,
  output logic       byte_valid,
  output logic [7:0] rx_byte
);
  import cfp_pkg::*;

  // Free when empty or when the held word moves on this cycle
  assign s_axis_tready = !byte_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_valid <= 1'b0;
    end else if (s_axis_tready) begin
      byte_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      rx_byte <= s_axis_tdata[IN_DATA_W-1:0];
    end
  end

endmodule

### rtl/core/cfp_parser.sv
module cfp_parser (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 byte_valid,
  input  logic [7:0]           rx_byte,
  input  logic                 out_free,
  output logic                 advance,
  output logic                 res_valid,
  output cfp_pkg::cfp_result_t res
);
  import cfp_pkg::*;

  phase_t     phase;
  phase_t     phase_next;
  kind_t      pending_kind;
  logic [7:0] held_hour;
  logic [7:0] bytes_left;
  logic [7:0] byte_position;
  kind_t      tcode;
  logic       emit;
  logic       pay_last;

  assign tcode    = type_code(rx_byte);
  assign pay_last = (bytes_left <= 8'd1);

  // A byte moves on unless its result has nowhere to go
  assign advance   = byte_valid && (!emit || out_free);
  assign res_valid = byte_valid && emit;

  // Next phase
  always_comb begin
    phase_next = phase;
    unique case (phase)
      PH_HUNT: begin
        if (rx_byte == CH_START) phase_next = PH_TYPE;
      end
      PH_TYPE: begin
        if (tcode == KIND_V) begin
          phase_next = PH_VOTE;
        end else if (tcode == KIND_H) begin
          phase_next = PH_HOUR;
        end else if (tcode >= KIND_N) begin
          phase_next = PH_LENGTH;
        end else begin
          phase_next = PH_HUNT;
        end
      end
      PH_VOTE:   phase_next = PH_HUNT;
      PH_HOUR:   phase_next = PH_MINUTE;
      PH_MINUTE: phase_next = PH_HUNT;
      PH_LENGTH: begin
        phase_next = (rx_byte == 8'd0) ? PH_HUNT : PH_PAYLOAD;
      end
      PH_PAYLOAD: begin
        if (pay_last) phase_next = PH_HUNT;
      end
      default: phase_next = PH_HUNT;
    endcase
  end

  // Result word for the current byte
  always_comb begin
    emit = 1'b0;
    res  = '0;
    res.frame_kind = KIND_INVALID;
    res.frame_last = 1'b1;
    unique case (phase)
      PH_HUNT: ;
      PH_TYPE: begin
        if (tcode == KIND_INVALID || tcode <= KIND_R) begin
          emit = 1'b1;
          res.frame_kind = tcode;
        end
      end
      PH_VOTE: begin
        emit = 1'b1;
        if (rx_byte == CH_OPT_O || rx_byte == CH_I || rx_byte == CH_OPT_X) begin
          res.frame_kind = KIND_V;
          res.arg_first  = rx_byte;
        end
      end
      PH_HOUR: ;
      PH_MINUTE: begin
        emit = 1'b1;
        if (held_hour < HOUR_LIMIT && rx_byte < MINUTE_LIMIT) begin
          res.frame_kind = KIND_H;
          res.arg_first  = held_hour;
          res.arg_second = rx_byte[5:0];
        end
      end
      PH_LENGTH: begin
        // empty payload still reports its frame
        if (rx_byte == 8'd0) begin
          emit = 1'b1;
          res.frame_kind = pending_kind;
        end
      end
      PH_PAYLOAD: begin
        emit = 1'b1;
        res.frame_kind    = pending_kind;
        res.arg_first     = rx_byte;
        res.payload_index = byte_position;
        res.has_payload   = 1'b1;
        res.frame_last    = pay_last;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_HUNT;
    end else if (advance) begin
      phase <= phase_next;
    end
  end

  // Frame context held across bytes
  always_ff @(posedge clk) begin
    if (rst) begin
      pending_kind  <= KIND_INVALID;
      held_hour     <= 8'd0;
      bytes_left    <= 8'd0;
      byte_position <= 8'd0;
    end else if (advance) begin
      unique case (phase)
        PH_TYPE: begin
          if (tcode >= KIND_N) pending_kind <= tcode;
        end
        PH_HOUR: held_hour <= rx_byte;
        PH_LENGTH: begin
          if (rx_byte != 8'd0) begin
            bytes_left    <= rx_byte;
            byte_position <= 8'd0;
          end
        end
        PH_PAYLOAD: begin
          bytes_left    <= bytes_left - 8'd1;
          byte_position <= byte_position + 8'd1;
        end
        default: ;
      endcase
    end
  end

endmodule

### rtl/core/cfp_out_stage.sv
module cfp_out_stage (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 load,
  input  cfp_pkg::cfp_result_t res,
  output logic                 out_free,
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output logic [23:0]          m_axis_tdata,
  output logic [4:0]           m_axis_tuser,
  output logic                 m_axis_tlast
);
  import cfp_pkg::*;

  cfp_result_t held;

  assign out_free = !m_axis_tvalid || m_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (load) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      held <= res;
    end
  end

  // Pack the held word onto the bus
  assign m_axis_tdata = {{(OUT_DATA_W - 22){1'b0}}, held.payload_index,
                         held.arg_second, held.arg_first};
  assign m_axis_tuser = {held.has_payload, held.frame_kind};
  assign m_axis_tlast = held.frame_last;

endmodule

### rtl/core/command_frame_parser_top.sv
// Command frame parser. Received bytes arrive on s_axis, one word per byte; the
// parser hunts for 'M', reads a type byte and its arguments, and gives out one
// result word per completed frame, or one per payload byte for N, P, S and F
// frames, or a single word if the length is zero (tlast marks the final word
// of a frame). Bad types or arguments give an invalid word with kind 0. A byte
// is taken every cycle while the output does not stall: each byte is held in
// the input register, parsed combinationally and its result word loaded into
// the output register, which drives m_axis.
// s_axis_tready falls only while the output register holds an untaken word
// and the waiting byte has a result of its own to deliver.
module command_frame_parser_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,   // [7:0] arg_first, [13:8] arg_second,
                                      // [21:14] payload_index, [23:22] zero
  output logic [4:0]  m_axis_tuser,   // [3:0] frame_kind, [4] has_payload
  output logic        m_axis_tlast    // frame_last
);
  import cfp_pkg::*;

  logic        byte_valid;
  logic [7:0]  rx_byte;
  logic        advance;
  logic        out_free;
  logic        res_valid;
  cfp_result_t res;

  cfp_in_stage u_in (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .advance       (advance),
    .byte_valid    (byte_valid),
    .rx_byte       (rx_byte)
  );

  cfp_parser u_parser (
    .clk        (clk),
    .rst        (rst),
    .byte_valid (byte_valid),
    .rx_byte    (rx_byte),
    .out_free   (out_free),
    .advance    (advance),
    .res_valid  (res_valid),
    .res        (res)
  );

  cfp_out_stage u_out (
    .clk           (clk),
    .rst           (rst),
    .load          (res_valid && advance),
    .res           (res),
    .out_free      (out_free),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

endmodule
